// File: hdl/rmfe_pkg.sv
// Package with the frame constants and the byte-wide CRC-16 step of the relay frame encoder.
`default_nettype none
package rmfe_pkg;

  localparam int DEFAULT_RELAY_COUNT = 8;
  localparam int MAX_RELAY_COUNT     = 8;
  localparam int BYTE_W              = 8;
  localparam int RELAY_NUM_W         = 4;
  localparam int POS_W               = 3;
  localparam int CRC_W               = 16;

  localparam logic [BYTE_W-1:0] DEV_ADDR     = 8'h01;
  localparam logic [BYTE_W-1:0] FUNC_WR_REG  = 8'h06;
  localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;
  localparam logic [BYTE_W-1:0] VAL_ON       = 8'h01;
  localparam logic [BYTE_W-1:0] VAL_OFF      = 8'h02;
  localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY     = 16'hA001;

  // Byte positions inside one write-single-register frame.
  localparam logic [POS_W-1:0] POS_ADDR     = 3'd0;
  localparam logic [POS_W-1:0] POS_FUNC     = 3'd1;
  localparam logic [POS_W-1:0] POS_REG_HI   = 3'd2;
  localparam logic [POS_W-1:0] POS_REG_LO   = 3'd3;
  localparam logic [POS_W-1:0] POS_VAL_HI   = 3'd4;
  localparam logic [POS_W-1:0] POS_VAL_LO   = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;

  // One byte through the reflected CRC-16/MODBUS register, eight shift steps.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rmfe_if.sv
// Request channel interfaces for relay states in and frame bytes out.
`default_nettype none
interface rmfe_in_if;
  logic                            valid;
  logic                            ready;
  logic [rmfe_pkg::BYTE_W-1:0]     relay_bits;

  modport source (output valid, output relay_bits, input ready);
  modport sink   (input valid, input relay_bits, output ready);
endinterface

interface rmfe_out_if;
  logic                              valid;
  logic                              ready;
  logic [rmfe_pkg::BYTE_W-1:0]       frame_byte;
  logic [rmfe_pkg::RELAY_NUM_W-1:0]  relay_number;
  logic [rmfe_pkg::POS_W-1:0]        byte_position;
  logic                              end_of_frame;
  logic                              last_of_run;

  modport source (output valid, output frame_byte, output relay_number,
                  output byte_position, output end_of_frame, output last_of_run,
                  input ready);
  modport sink   (input valid, input frame_byte, input relay_number,
                  input byte_position, input end_of_frame, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/relay_modbus_frame_encoder_unit.sv
// Top level: relay state to Modbus RTU write-single-register frame encoder.
//
// A request on in_ch carries the wanted on/off state of RELAY_COUNT relays.
// The block compares it with the state it last sent (all relays are taken
// as off while the simulation register is set) and, for each changed relay
// in ascending order, sends an eight-byte frame on out_ch, one byte per
// request. After reset every relay gets a frame on the first request.
// The simulation register is written through cfg_wr_en / cfg_wr_data.
// Sequence: after a request is taken, the sequencer scans the relays in
// ascending order, sends a frame for each changed relay and, once no change
// is left, returns to idle after a closing scan; when nothing changed it
// returns after that closing scan alone.
// The pace is set by the one byte per cycle that leaves through the output
// register while out_ch does not stall, and the shared CRC unit folds each
// header byte as it is sent.
// in_ch.ready is high only while the sequencer is idle; a new request can be
// taken while the final byte still waits in the output register.
// When the receiver stalls, the output byte holds and the sequencer waits.
// Reset clears the sent state, sets the first-run flag and the simulation
// register, and empties the output register.
`default_nettype none
module relay_modbus_frame_encoder_unit #(
  parameter int RELAY_COUNT = rmfe_pkg::DEFAULT_RELAY_COUNT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rmfe_in_if.sink       in_ch,
  rmfe_out_if.source    out_ch,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data
);

  localparam int IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SEND} state_t;

  state_t                           state_r;
  logic                             sim_r;
  logic                             first_r;
  logic [RELAY_COUNT-1:0]           sent_r;
  logic [RELAY_COUNT-1:0]           want_r;
  logic [RELAY_COUNT-1:0]           chg_r;
  logic [IDX_W-1:0]                 idx_r;
  logic [rmfe_pkg::POS_W-1:0]       pos_r;
  logic [rmfe_pkg::CRC_W-1:0]       crc_r;
  logic [rmfe_pkg::CRC_W-1:0]       crc_nxt;

  logic                             out_valid_r;
  logic [rmfe_pkg::BYTE_W-1:0]      out_byte_r;
  logic [rmfe_pkg::RELAY_NUM_W-1:0] out_relay_r;
  logic [rmfe_pkg::POS_W-1:0]       out_pos_r;
  logic                             out_eof_r;
  logic                             out_last_r;

  logic                             in_take;
  logic                             out_free;
  logic [RELAY_COUNT-1:0]           want_in;
  logic [RELAY_COUNT-1:0]           chg_left;
  logic [rmfe_pkg::BYTE_W-1:0]      tx_byte;
  logic [rmfe_pkg::RELAY_NUM_W-1:0] relay_num;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign want_in     = sim_r ? '0 : in_ch.relay_bits[RELAY_COUNT-1:0];
  assign relay_num   = rmfe_pkg::RELAY_NUM_W'(idx_r) + 4'd1;

  // Changes still pending once the current relay's frame is done.
  always_comb begin
    chg_left        = chg_r;
    chg_left[idx_r] = 1'b0;
  end

  always_comb begin
    unique case (pos_r)
      rmfe_pkg::POS_ADDR:   tx_byte = rmfe_pkg::DEV_ADDR;
      rmfe_pkg::POS_FUNC:   tx_byte = rmfe_pkg::FUNC_WR_REG;
      rmfe_pkg::POS_REG_HI: tx_byte = rmfe_pkg::ZERO_BYTE;
      rmfe_pkg::POS_REG_LO: tx_byte = rmfe_pkg::BYTE_W'(relay_num);
      rmfe_pkg::POS_VAL_HI: tx_byte = want_r[idx_r] ? rmfe_pkg::VAL_ON : rmfe_pkg::VAL_OFF;
      rmfe_pkg::POS_VAL_LO: tx_byte = rmfe_pkg::ZERO_BYTE;
      rmfe_pkg::POS_CRC_LO: tx_byte = crc_r[7:0];
      rmfe_pkg::POS_CRC_HI: tx_byte = crc_r[15:8];
      default:              tx_byte = rmfe_pkg::ZERO_BYTE;
    endcase
  end

  assign crc_nxt = rmfe_pkg::crc16_byte(crc_r, tx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sim_r       <= 1'b1;
      first_r     <= 1'b1;
      sent_r      <= '0;
      chg_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sim_r <= cfg_wr_data;
      end
      if (state_r == ST_SEND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            want_r  <= want_in;
            chg_r   <= first_r ? '1 : (want_in ^ sent_r);
            sent_r  <= want_in;
            first_r <= 1'b0;
            idx_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chg_r == '0) begin
            state_r <= ST_IDLE;
          end else if (chg_r[idx_r]) begin
            pos_r   <= '0;
            crc_r   <= rmfe_pkg::CRC_INIT;
            state_r <= ST_SEND;
          end else begin
            idx_r <= IDX_W'(idx_r + 1'b1);
          end
        end
        ST_SEND: begin
          if (out_free) begin
            out_byte_r  <= tx_byte;
            out_relay_r <= relay_num;
            out_pos_r   <= pos_r;
            out_eof_r   <= (pos_r == rmfe_pkg::POS_CRC_HI);
            out_last_r  <= (pos_r == rmfe_pkg::POS_CRC_HI) && (chg_left == '0);
            // The CRC covers the six header bytes only; it holds while it is sent.
            if (pos_r < rmfe_pkg::POS_CRC_LO) begin
              crc_r <= crc_nxt;
            end
            pos_r       <= rmfe_pkg::POS_W'(pos_r + 1'b1);
            if (pos_r == rmfe_pkg::POS_CRC_HI) begin
              chg_r   <= chg_left;
              idx_r   <= IDX_W'(idx_r + 1'b1);
              state_r <= ST_SCAN;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_byte    = out_byte_r;
  assign out_ch.relay_number  = out_relay_r;
  assign out_ch.byte_position = out_pos_r;
  assign out_ch.end_of_frame  = out_eof_r;
  assign out_ch.last_of_run   = out_last_r;

endmodule
`default_nettype wire

// File: hdl/rmfe_checker.sv
// Port-level checker for the relay frame encoder, bound to the top level.
`default_nettype none
module rmfe_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [rmfe_pkg::BYTE_W-1:0]      frame_byte,
  input wire logic [rmfe_pkg::POS_W-1:0]       byte_position,
  input wire logic                             end_of_frame,
  input wire logic                             last_of_run
);

  // A stalled output byte keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte)
                               && $stable(byte_position))
    else $error("output request changed while stalled");

  // The closing flag marks exactly the CRC high byte.
  a_eof_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> end_of_frame == (byte_position == rmfe_pkg::POS_CRC_HI))
    else $error("end_of_frame does not match byte position");

  // A run can only end on a frame boundary.
  a_last_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_of_run |-> end_of_frame)
    else $error("last_of_run inside a frame");

  // Inside a frame the next byte follows right after the previous one is taken.
  a_next_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !end_of_frame |=>
      out_valid && byte_position == rmfe_pkg::POS_W'($past(byte_position) + 3'd1))
    else $error("frame bytes not contiguous");

  // No new relay state is taken while a frame is half sent.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !end_of_frame |-> !in_ready)
    else $error("input ready in the middle of a frame");

endmodule

bind relay_modbus_frame_encoder_unit rmfe_checker u_rmfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .frame_byte    (out_ch.frame_byte),
  .byte_position (out_ch.byte_position),
  .end_of_frame  (out_ch.end_of_frame),
  .last_of_run   (out_ch.last_of_run)
);
`default_nettype wire
